FILE: sv/rrtt_pkg.sv
// ----------------------------------------------------------------------------
// rrtt_pkg
// Types and codes shared by the timer table modules.
// ----------------------------------------------------------------------------
package rrtt_pkg;

   // number of timer slots; slot ids on the ports are 4 bits wide
   localparam int MAX_TIMERS = 16;

   typedef enum logic [1:0] {
      OP_SET  = 2'd0,
      OP_KILL = 2'd1,
      OP_SCAN = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LINK,
      ST_FIX,
      ST_DONE
   } state_type;

endpackage

FILE: sv/round_robin_timer_table.sv
// ----------------------------------------------------------------------------
// round_robin_timer_table
// Timer slot table kept as a doubly linked list, walked round-robin by scans.
// ----------------------------------------------------------------------------
// The rsp_valid strobe follows acceptance through the states ST_READ, which
// reads the slot record from the slot memory, ST_LINK, which rewrites the
// record and the links of its neighbors, ST_FIX, a second link state only
// for a set appended behind an existing tail (one memory write port), and
// ST_DONE, which presents the result. busy is high from acceptance through
// the strobe cycle, so no request is accepted until the last one is through.
// A set takes the lowest free slot, found combinationally from the active bits.
// The receiver cannot stall; every request gives exactly one result strobe.
module round_robin_timer_table
   import rrtt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [30:0] req_period_sec,
   input  logic [31:0] req_repeat_count,
   input  logic [31:0] req_user_tag,
   input  logic [3:0]  req_slot_id,
   input  logic [30:0] req_now_sec,
   input  logic [19:0] req_now_usec,
   output logic        rsp_valid,
   output logic        rsp_fired,
   output logic [3:0]  rsp_fired_slot,
   output logic [31:0] rsp_fired_tag,
   output logic        rsp_set_ok,
   output logic [3:0]  rsp_set_slot
);

   localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam int PW = $clog2(MAX_TIMERS + 1);
   localparam logic [PW-1:0] NIL = PW'(MAX_TIMERS);

   // slot record memory and link memories
   logic [30:0]   mem_period [MAX_TIMERS];
   logic [30:0]   mem_bsec   [MAX_TIMERS];
   logic [19:0]   mem_busec  [MAX_TIMERS];
   logic [31:0]   mem_rem    [MAX_TIMERS];
   logic [31:0]   mem_tag    [MAX_TIMERS];
   logic [PW-1:0] mem_next   [MAX_TIMERS];
   logic [PW-1:0] mem_prev   [MAX_TIMERS];

   logic [MAX_TIMERS-1:0] active_ff, active_in;
   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in, scan_ff, scan_in;
   state_type state_ff, state_in;

   // captured request
   op_type        op_ff;
   logic [30:0]   per_ff, nsec_ff;
   logic [31:0]   cnt_ff, tag_ff;
   logic [19:0]   nusec_ff;
   logic [AW-1:0] slot_ff, slot_in;
   logic          hit_ff, hit_in;

   // registered read data
   logic [30:0]   rd_period, rd_bsec;
   logic [19:0]   rd_busec;
   logic [31:0]   rd_rem, rd_tag;
   logic [PW-1:0] rd_next, rd_prev;

   // result registers
   logic        fired_ff, fired_in, setok_ff, setok_in;
   logic [31:0] ftag_ff, ftag_in;

   // second link fix: next pointer of the old tail
   logic          fix_in;
   logic [AW-1:0] fixa_ff, fixa_in;
   logic [PW-1:0] fixv_ff, fixv_in;

   // one memory write port per array
   logic          wr_rec, wr_time, wr_rem, wr_nx, wr_pv;
   logic [AW-1:0] wa_rec, wa_nx, wa_pv;
   logic [PW-1:0] wd_nx, wd_pv;
   logic [31:0]   wd_rem;

   logic [AW-1:0] free_idx;
   logic          free_ok;
   logic [AW-1:0] rd_addr;
   logic [31:0]   deadline;
   logic          expired;
   logic          accept;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      free_idx = '0;
      free_ok  = 1'b0;
      for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_idx = AW'(i);
            free_ok  = 1'b1;
         end
      end
   end

   // scan restarts at head when the pointer is null
   always_comb begin
      if (scan_ff != NIL) rd_addr = scan_ff[AW-1:0];
      else                rd_addr = head_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_period <= mem_period[slot_ff];
         rd_bsec   <= mem_bsec[slot_ff];
         rd_busec  <= mem_busec[slot_ff];
         rd_rem    <= mem_rem[slot_ff];
         rd_tag    <= mem_tag[slot_ff];
         rd_next   <= mem_next[slot_ff];
         rd_prev   <= mem_prev[slot_ff];
      end
      if (wr_rec) begin
         mem_period[wa_rec] <= per_ff;
         mem_tag[wa_rec]    <= tag_ff;
      end
      if (wr_time) begin
         mem_bsec[wa_rec]  <= nsec_ff;
         mem_busec[wa_rec] <= nusec_ff;
      end
      if (wr_rem) mem_rem[wa_rec] <= wd_rem;
      if (wr_nx)  mem_next[wa_nx] <= wd_nx;
      if (wr_pv)  mem_prev[wa_pv] <= wd_pv;
   end

   assign deadline = {1'b0, rd_period} + {1'b0, rd_bsec};
   assign expired  = (deadline < {1'b0, nsec_ff}) ||
                     ((deadline == {1'b0, nsec_ff}) && (rd_busec <= nusec_ff));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_READ;
         ST_READ: state_in = ST_LINK;
         ST_LINK: state_in = fix_in ? ST_FIX : ST_DONE;
         ST_FIX:  state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      active_in = active_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      scan_in   = scan_ff;
      slot_in   = slot_ff;
      hit_in    = hit_ff;
      fired_in  = fired_ff;
      setok_in  = setok_ff;
      ftag_in   = ftag_ff;
      fix_in    = 1'b0;
      fixa_in   = fixa_ff;
      fixv_in   = fixv_ff;
      wr_rec = 1'b0; wr_time = 1'b0; wr_rem = 1'b0; wr_nx = 1'b0; wr_pv = 1'b0;
      wa_rec = slot_ff; wa_nx = slot_ff; wa_pv = slot_ff;
      wd_nx  = NIL; wd_pv = NIL;
      wd_rem = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fired_in = 1'b0;
               setok_in = 1'b0;
               ftag_in  = '0;
               hit_in   = 1'b0;
               case (op_type'(req_op))
                  OP_SET: begin
                     slot_in = free_idx;
                     hit_in  = free_ok;
                  end
                  OP_KILL: begin
                     slot_in = req_slot_id[AW-1:0];
                     hit_in  = ({28'd0, req_slot_id} < 32'(MAX_TIMERS)) &&
                               active_ff[req_slot_id[AW-1:0]];
                  end
                  OP_SCAN: begin
                     slot_in = rd_addr;
                     hit_in  = (scan_ff != NIL) || (head_ff != NIL);
                     if (scan_ff == NIL) scan_in = head_ff;
                  end
                  default: hit_in = 1'b0;
               endcase
            end
         end
         ST_READ: ;
         ST_LINK: begin
            if (hit_ff) begin
               case (op_ff)
                  OP_SET: begin
                     setok_in = 1'b1;
                     active_in[slot_ff] = 1'b1;
                     wr_rec = 1'b1; wr_time = 1'b1; wr_rem = 1'b1;
                     wr_pv = 1'b1; wd_pv = tail_ff;
                     // own next is NIL; old tail next gets this slot (fix cycle)
                     wr_nx = 1'b1; wd_nx = NIL;
                     if (tail_ff != NIL) begin
                        fix_in  = 1'b1;
                        fixa_in = tail_ff[AW-1:0];
                        fixv_in = PW'(slot_ff);
                     end else begin
                        head_in = PW'(slot_ff);
                     end
                     tail_in = PW'(slot_ff);
                  end
                  OP_KILL, OP_SCAN: begin
                     if (op_ff == OP_SCAN) scan_in = rd_next;
                     else if (scan_ff == PW'(slot_ff)) scan_in = rd_next;
                     if (op_ff == OP_SCAN && expired) begin
                        fired_in = 1'b1;
                        ftag_in  = rd_tag;
                        wr_time  = 1'b1;
                        wr_rem   = 1'b1;
                        wd_rem   = rd_rem - 32'd1;
                        if (rd_rem == 32'd0) wr_rem = 1'b0;
                     end
                     if (op_ff == OP_KILL || (expired && rd_rem == 32'd1)) begin
                        active_in[slot_ff] = 1'b0;
                        if (rd_prev != NIL) begin
                           wr_nx = 1'b1; wa_nx = rd_prev[AW-1:0]; wd_nx = rd_next;
                        end else begin
                           head_in = rd_next;
                        end
                        if (rd_next != NIL) begin
                           wr_pv = 1'b1; wa_pv = rd_next[AW-1:0]; wd_pv = rd_prev;
                        end else begin
                           tail_in = rd_prev;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FIX: begin
            wr_nx = 1'b1; wa_nx = fixa_ff; wd_nx = fixv_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         active_ff <= '0;
         head_ff   <= NIL;
         tail_ff   <= NIL;
         scan_ff   <= NIL;
         hit_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         scan_ff   <= scan_in;
         hit_ff    <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= op_type'(req_op);
         per_ff   <= req_period_sec;
         cnt_ff   <= req_repeat_count;
         tag_ff   <= req_user_tag;
         nsec_ff  <= req_now_sec;
         nusec_ff <= req_now_usec;
      end
      slot_ff  <= slot_in;
      fired_ff <= fired_in;
      setok_ff <= setok_in;
      ftag_ff  <= ftag_in;
      fixa_ff  <= fixa_in;
      fixv_ff  <= fixv_in;
   end

   assign rsp_valid      = (state_ff == ST_DONE);
   assign rsp_fired      = fired_ff;
   assign rsp_fired_slot = fired_ff ? 4'(slot_ff) : 4'd0;
   assign rsp_fired_tag  = ftag_ff;
   assign rsp_set_ok     = setok_ff;
   assign rsp_set_slot   = setok_ff ? 4'(slot_ff) : 4'd0;

`ifndef SYNTHESIS
   a_fix_only_after_link: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |-> $past(state_ff) == ST_LINK)
      else $error("link fix out of order");
   a_head_tail_null: assert property (@(posedge clock) disable iff (reset)
      (head_ff == NIL) == (tail_ff == NIL))
      else $error("list head and tail disagree");
   a_empty_inactive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && head_ff == NIL) |-> active_ff == '0)
      else $error("active slot outside list");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("double result strobe");
`endif

endmodule

FILE: dv/round_robin_timer_table_tb.sv
// ----------------------------------------------------------------------------
// round_robin_timer_table_tb
// Self-checking bench for the timer table. A directed table of requests runs
// first, then a table-full fill and random set/kill/scan/none traffic; every
// response is checked against a behavioral model of the slot list in the bench.
// ----------------------------------------------------------------------------
module round_robin_timer_table_tb
   import rrtt_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 16;
   localparam int NIL = NSLOT;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [1:0]  op;
      logic [30:0] period;
      logic [31:0] count;
      logic [31:0] tag;
      logic [3:0]  sid;
      logic [30:0] nsec;
      logic [19:0] nusec;
   } timer_req_type;

   typedef struct packed {
      logic        fired;
      logic [3:0]  fired_slot;
      logic [31:0] fired_tag;
      logic        set_ok;
      logic [3:0]  set_slot;
   } timer_rsp_type;

   typedef struct {
      timer_req_type req;
      logic          has_exp;
      timer_rsp_type exp;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = '0;
   logic [30:0] req_period_sec = '0;
   logic [31:0] req_repeat_count = '0;
   logic [31:0] req_user_tag = '0;
   logic [3:0]  req_slot_id = '0;
   logic [30:0] req_now_sec = '0;
   logic [19:0] req_now_usec = '0;
   logic        rsp_valid;
   logic        rsp_fired;
   logic [3:0]  rsp_fired_slot;
   logic [31:0] rsp_fired_tag;
   logic        rsp_set_ok;
   logic [3:0]  rsp_set_slot;

   round_robin_timer_table dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // model state
   logic        m_active [NSLOT];
   logic [30:0] m_period [NSLOT];
   logic [30:0] m_bsec [NSLOT];
   logic [19:0] m_busec [NSLOT];
   logic [31:0] m_remain [NSLOT];
   logic [31:0] m_tag [NSLOT];
   int          m_next [NSLOT];
   int          m_prev [NSLOT];
   int          m_head, m_tail, m_scan;

   timer_rsp_type expected_rsps [$];
   int mismatches = 0;
   int fired_seen = 0;
   int sets_ok = 0;
   int accepted = 0;
   int idle_pct = 0;
   int watchdog = 0;
   logic timed_out = 1'b0;

   // current simulated time carried by requests
   logic [30:0] clk_sec = 31'd100;
   logic [19:0] clk_usec = '0;

   task automatic model_unlink(input int s);
      int p, n;
      p = m_prev[s];
      n = m_next[s];
      if (p < NIL) m_next[p] = n; else m_head = n;
      if (n < NIL) m_prev[n] = p; else m_tail = p;
      m_active[s] = 1'b0;
   endtask

   function automatic int active_count();
      int c = 0;
      for (int i = 0; i < NSLOT; i++) c += m_active[i];
      return c;
   endfunction

   task automatic predict_timer(input timer_req_type r, output timer_rsp_type o);
      int s;
      logic [31:0] deadline;
      o = '0;
      case (op_type'(r.op))
         OP_SET: begin
            s = NIL;
            for (int i = NSLOT - 1; i >= 0; i--) if (!m_active[i]) s = i;
            if (s < NIL) begin
               m_active[s] = 1'b1;
               m_period[s] = r.period;
               m_remain[s] = r.count;
               m_tag[s] = r.tag;
               m_bsec[s] = r.nsec;
               m_busec[s] = r.nusec;
               m_next[s] = NIL;
               m_prev[s] = m_tail;
               if (m_tail < NIL) m_next[m_tail] = s; else m_head = s;
               m_tail = s;
               o.set_ok = 1'b1;
               o.set_slot = s[3:0];
            end
         end
         OP_KILL: begin
            s = r.sid;
            if (s < NSLOT && m_active[s]) begin
               if (m_scan == s) m_scan = m_next[s];
               model_unlink(s);
            end
         end
         OP_SCAN: begin
            if (m_scan >= NIL) m_scan = m_head;
            if (m_scan < NIL) begin
               s = m_scan;
               deadline = {1'b0, m_period[s]} + {1'b0, m_bsec[s]};
               m_scan = m_next[s];
               if (deadline < {1'b0, r.nsec} ||
                   (deadline == {1'b0, r.nsec} && m_busec[s] <= r.nusec)) begin
                  o.fired = 1'b1;
                  o.fired_slot = s[3:0];
                  o.fired_tag = m_tag[s];
                  m_bsec[s] = r.nsec;
                  m_busec[s] = r.nusec;
                  if (m_remain[s] != 32'd0) begin
                     m_remain[s]--;
                     if (m_remain[s] == 32'd0) model_unlink(s);
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   // response checker
   always @(posedge clock) begin
      timer_rsp_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_fired, rsp_fired_slot, rsp_fired_tag, rsp_set_ok, rsp_set_slot};
         if (got.fired) fired_seen++;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp fired=%0d slot=%0d tag=%h ok=%0d sslot=%0d",
                            " | got fired=%0d slot=%0d tag=%h ok=%0d sslot=%0d"},
                           want.fired, want.fired_slot, want.fired_tag, want.set_ok,
                           want.set_slot, got.fired, got.fired_slot, got.fired_tag,
                           got.set_ok, got.set_slot);
            end
         end
      end
   end

   // watchdog on cycles without any accepted request or response
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("watchdog expired");
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // start stays high from one request to the next unless the sender idles
   task automatic send_request(input timer_req_type r, input logic has_exp,
                               input timer_rsp_type typed);
      timer_rsp_type o;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_op <= r.op;
      req_period_sec <= r.period;
      req_repeat_count <= r.count;
      req_user_tag <= r.tag;
      req_slot_id <= r.sid;
      req_now_sec <= r.nsec;
      req_now_usec <= r.nusec;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_timer(r, o);
      if (has_exp && o !== typed) begin
         mismatches++;
         if (mismatches <= 10)
            $display("directed row disagrees with model: %h vs %h", typed, o);
      end
      expected_rsps.push_back(o);
      accepted++;
   endtask

   function automatic timer_req_type mk(input op_type op, input logic [30:0] period,
                                        input logic [31:0] count, input logic [31:0] tag,
                                        input logic [3:0] sid, input logic [30:0] nsec,
                                        input logic [19:0] nusec);
      mk = '{op, period, count, tag, sid, nsec, nusec};
   endfunction

   function automatic timer_req_type random_request();
      timer_req_type r;
      int pick;
      r.period = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(4));
      r.count = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(3));
      r.tag = $urandom;
      r.sid = 4'($urandom_range(15));
      // time mostly moves forward slowly; sometimes jumps anywhere
      if ($urandom_range(19) == 0) begin
         clk_sec = 31'($urandom);
         clk_usec = 20'($urandom);
      end else begin
         clk_sec = clk_sec + 31'($urandom_range(1));
         clk_usec = ($urandom_range(15) == 0) ? 20'($urandom) : 20'($urandom_range(999999));
      end
      r.nsec = clk_sec;
      r.nusec = clk_usec;
      pick = $urandom_range(99);
      if (pick < 30) r.op = OP_SET;
      else if (pick < 45) r.op = OP_KILL;
      else if (pick < 97) r.op = OP_SCAN;
      else r.op = OP_NONE;
      if (r.op == OP_KILL && $urandom_range(1)) begin
         for (int k = 0; k < 4; k++) begin
            if (m_active[r.sid]) break;
            r.sid = 4'($urandom_range(15));
         end
      end
      return r;
   endfunction

   dir_row_type dir_rows [$];

   initial begin
      timer_rsp_type none;
      timer_rsp_type e;
      none = '0;
      for (int i = 0; i < NSLOT; i++) begin
         m_active[i] = 1'b0; m_period[i] = '0; m_bsec[i] = '0; m_busec[i] = '0;
         m_remain[i] = '0; m_tag[i] = '0; m_next[i] = 0; m_prev[i] = 0;
      end
      m_head = NIL; m_tail = NIL; m_scan = NIL;

      // directed table
      dir_rows.push_back('{mk(OP_SCAN, '0, '0, '0, '0, '0, '0), 1'b1, none});  // empty scan
      dir_rows.push_back('{mk(OP_KILL, '0, '0, '0, 4'd5, '0, '0), 1'b1, none}); // free slot
      dir_rows.push_back('{mk(OP_NONE, '1, '1, '1, '1, '1, '1), 1'b1, none});  // unused op
      e = '0; e.set_ok = 1'b1; e.set_slot = '0;
      dir_rows.push_back('{mk(OP_SET, '0, 32'd1, 32'hFFFF_FFFF, '0, '0, '0), 1'b1, e});
      e.fired = 1'b1; e.fired_tag = 32'hFFFF_FFFF; e.set_ok = 1'b0;
      dir_rows.push_back('{mk(OP_SCAN, '0, '0, '0, '0, '0, '0), 1'b1, e});      // last firing
      dir_rows.push_back('{mk(OP_SET, '1, '0, 32'h1234_5678, '0, '1, 20'hFFFFF), 1'b0, none});
      dir_rows.push_back('{mk(OP_SCAN, '0, '0, '0, '0, '1, 20'hFFFFE), 1'b0, none});
      dir_rows.push_back('{mk(OP_SCAN, '0, '0, '0, '0, '1, 20'hFFFFF), 1'b0, none});
      for (int i = 0; i < 16; i++)
         dir_rows.push_back('{mk(OP_SET, 31'(i % 3), 32'(i % 2), 32'(i * 32'h1111), '0,
                                 31'd10, 20'd999999), 1'b0, none});
      dir_rows.push_back('{mk(OP_SCAN, '0, '0, '0, '0, 31'd20, '0), 1'b0, none});
      dir_rows.push_back('{mk(OP_KILL, '0, '0, '0, 4'd1, '0, '0), 1'b0, none}); // slot under scan pointer
      dir_rows.push_back('{mk(OP_SCAN, '0, '0, '0, '0, 31'd20, '0), 1'b0, none});

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_request(dir_rows[i].req, dir_rows[i].has_exp, dir_rows[i].exp);

      // table-full case: fill up, then one extra set
      while (active_count() < NSLOT)
         send_request(mk(OP_SET, 31'd1000, '0, $urandom, '0, clk_sec, '0), 1'b0, none);
      send_request(mk(OP_SET, 31'd1, 32'd1, 32'hDEAD, '0, clk_sec, '0), 1'b1, none);

      // hold off until every outstanding response is back
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 33 : (phase == 1) ? 57 : 0;
         for (int n = 0; n < 480; n++) begin
            if (active_count() == NSLOT && $urandom_range(3) != 0) begin
               timer_req_type k;
               k = mk(OP_KILL, '0, '0, '0, 4'($urandom_range(15)), clk_sec, '0);
               send_request(k, 1'b0, none);
            end else begin
               send_request(random_request(), 1'b0, none);
            end
         end
      end

      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d requests accepted, %0d timers set, %0d firings observed",
               accepted, sets_ok, fired_seen);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   always @(posedge clock) if (!reset && rsp_valid && rsp_set_ok) sets_ok++;

endmodule
